// File: design/tapid_pkg.sv
// ----------------------------------------------------------------------------
// tapid_pkg
// Shared types and constants for the heading PID with settle counting.
// ----------------------------------------------------------------------------
package tapid_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_BOUND  = 3'd3,
    CFG_MAX    = 3'd4,
    CFG_MIN    = 3'd5,
    CFG_SETTLE = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_START  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  typedef struct packed {
    logic [23:0] kp_gain;
    logic [23:0] ki_times_dt;
    logic [23:0] kd_over_dt;
    logic [14:0] error_bound;
    logic [7:0]  max_speed;
    logic [7:0]  min_speed;
    logic [3:0]  settle_count;
  } cfg_t;

  localparam logic [23:0] KP_RST     = 24'd6554;
  localparam logic [14:0] BOUND_RST  = 15'd10;
  localparam logic [7:0]  MAX_RST    = 8'd128;
  localparam logic [7:0]  MIN_RST    = 8'd13;
  localparam logic [3:0]  SETTLE_RST = 4'd8;

  localparam cfg_t CFG_RST = '{
    kp_gain:      KP_RST,
    ki_times_dt:  24'd0,
    kd_over_dt:   24'd0,
    error_bound:  BOUND_RST,
    max_speed:    MAX_RST,
    min_speed:    MIN_RST,
    settle_count: SETTLE_RST
  };

  // Stored error after reset is twice the reset bound
  localparam logic signed [15:0] LAST_ERR_RST = 16'(2 * BOUND_RST);

  // Angle wrap, centidegrees, on the 18-bit raw error
  localparam logic signed [17:0] HALF_TURN = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;
  localparam logic signed [17:0] NEG_WRAP1 = -HALF_TURN;
  localparam logic signed [17:0] NEG_WRAP2 = -(HALF_TURN + FULL_TURN);
  localparam logic signed [17:0] NEG_WRAP3 = -(HALF_TURN + 18'sd2 * FULL_TURN);
  localparam logic signed [17:0] POS_WRAP1 = HALF_TURN;
  localparam logic signed [17:0] POS_WRAP2 = HALF_TURN + FULL_TURN;
  localparam logic signed [17:0] POS_WRAP3 = HALF_TURN + 18'sd2 * FULL_TURN;

  localparam int FRAC_W = 16;
  localparam int ACC_W  = 58;

  // After the state stage
  typedef struct packed {
    logic               drive_en;
    logic signed [15:0] err;
    logic signed [31:0] sum;
    logic signed [16:0] de;
    logic               busy;
    logic               fin;
  } s1_t;

  // After the multiplier stage
  typedef struct packed {
    logic               drive_en;
    logic signed [40:0] p_kp;
    logic signed [56:0] p_ki;
    logic signed [41:0] p_kd;
    logic signed [15:0] err;
    logic               busy;
    logic               fin;
  } s2_t;

  // After the accumulate stage
  typedef struct packed {
    logic                   drive_en;
    logic signed [ACC_W-1:0] acc;
    logic signed [15:0]     err;
    logic                   busy;
    logic                   fin;
  } s3_t;

endpackage

// File: design/tapid_cfg.sv
// ----------------------------------------------------------------------------
// tapid_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module tapid_cfg
  import tapid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_KP:     cfg_d.kp_gain      = data_i;
        CFG_KI:     cfg_d.ki_times_dt  = data_i;
        CFG_KD:     cfg_d.kd_over_dt   = data_i;
        CFG_BOUND:  cfg_d.error_bound  = data_i[14:0];
        CFG_MAX:    cfg_d.max_speed    = data_i[7:0];
        CFG_MIN:    cfg_d.min_speed    = data_i[7:0];
        CFG_SETTLE: cfg_d.settle_count = data_i[3:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/tapid_state.sv
// ----------------------------------------------------------------------------
// tapid_state
// Turn state, settle counter, angle wrap and saturating error sum.
// ----------------------------------------------------------------------------
module tapid_state
  import tapid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_rdy_o,
  input  logic               req_type_i,
  input  logic signed [15:0] target_angle_i,
  input  logic signed [15:0] yaw_reading_i,
  input  cfg_t               cfg_i,
  input  logic               dn_rdy_i,
  output logic               valid_o,
  output s1_t                s1_o
);

  logic               valid_q;
  s1_t                s1_q, s1_d;
  logic signed [15:0] goal_q, goal_d;
  logic signed [15:0] start_yaw_q, start_yaw_d;
  logic signed [15:0] last_err_q, last_err_d;
  logic signed [31:0] sum_q, sum_d;
  logic [3:0]         settle_q, settle_d;
  logic               running_q, running_d;
  logic               first_q, first_d;

  logic               take;
  logic signed [15:0] twice_bound;
  logic signed [16:0] last_abs;
  logic [3:0]         settle_nx;
  logic signed [17:0] raw_err, wrap_adj, wrapped;
  logic signed [15:0] err;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [15:0] prev;

  assign in_rdy_o = !valid_q || dn_rdy_i;
  assign take     = in_valid_i && in_rdy_o;

  assign twice_bound = cfg_i.error_bound[14] ? 16'sh7FFF
                                             : $signed({1'b0, cfg_i.error_bound[13:0], 1'b0});

  // Settle counter runs on the error left by the previous sample
  assign last_abs  = last_err_q[15] ? 17'sd0 - 17'(last_err_q) : 17'(last_err_q);
  assign settle_nx = (last_abs < $signed({2'b00, cfg_i.error_bound}))
                   ? ((settle_q != 4'd0) ? settle_q - 4'd1 : 4'd0)
                   : cfg_i.settle_count;

  assign raw_err = 18'(goal_q) - (18'(yaw_reading_i) - 18'(start_yaw_q));

  always_comb begin
    priority if (raw_err < NEG_WRAP3) wrap_adj = 18'sd3 * FULL_TURN;
    else if (raw_err < NEG_WRAP2)     wrap_adj = 18'sd2 * FULL_TURN;
    else if (raw_err < NEG_WRAP1)     wrap_adj = FULL_TURN;
    else if (raw_err > POS_WRAP3)     wrap_adj = -(18'sd3 * FULL_TURN);
    else if (raw_err > POS_WRAP2)     wrap_adj = -(18'sd2 * FULL_TURN);
    else if (raw_err > POS_WRAP1)     wrap_adj = -FULL_TURN;
    else                              wrap_adj = 18'sd0;
  end

  assign wrapped = raw_err + wrap_adj;
  assign err     = wrapped[15:0];

  assign sum_wide = 33'(sum_q) + 33'(err);
  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  assign prev = first_q ? 16'sd0 : last_err_q;

  always_comb begin
    goal_d      = goal_q;
    start_yaw_d = start_yaw_q;
    last_err_d  = last_err_q;
    sum_d       = sum_q;
    settle_d    = settle_q;
    running_d   = running_q;
    first_d     = first_q;
    s1_d        = '0;
    if (take) begin
      if (req_type_i == REQ_START) begin
        goal_d      = target_angle_i;
        start_yaw_d = yaw_reading_i;
        sum_d       = '0;
        last_err_d  = twice_bound;
        settle_d    = cfg_i.settle_count;
        running_d   = 1'b1;
        first_d     = 1'b1;
        s1_d.busy   = 1'b1;
      end else if (running_q) begin
        settle_d      = settle_nx;
        sum_d         = sum_sat;
        last_err_d    = err;
        first_d       = 1'b0;
        running_d     = (settle_nx != 4'd0);
        s1_d.drive_en = 1'b1;
        s1_d.err      = err;
        s1_d.sum      = sum_sat;
        s1_d.de       = 17'(err) - 17'(prev);
        s1_d.busy     = (settle_nx != 4'd0);
        s1_d.fin      = (settle_nx == 4'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      goal_q      <= '0;
      start_yaw_q <= '0;
      last_err_q  <= LAST_ERR_RST;
      sum_q       <= '0;
      settle_q    <= '0;
      running_q   <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      if (in_rdy_o) begin
        valid_q <= in_valid_i;
      end
      goal_q      <= goal_d;
      start_yaw_q <= start_yaw_d;
      last_err_q  <= last_err_d;
      sum_q       <= sum_d;
      settle_q    <= settle_d;
      running_q   <= running_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

// File: design/tapid_mac.sv
// ----------------------------------------------------------------------------
// tapid_mac
// Gain multipliers followed by the three-term accumulate, two stages.
// ----------------------------------------------------------------------------
module tapid_mac
  import tapid_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic up_valid_i,
  output logic up_rdy_o,
  input  s1_t  s1_i,
  input  cfg_t cfg_i,
  input  logic dn_rdy_i,
  output logic valid_o,
  output s3_t  s3_o
);

  logic s2_valid_q, s3_valid_q;
  logic s2_rdy, s3_rdy;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;

  assign s3_rdy   = !s3_valid_q || dn_rdy_i;
  assign s2_rdy   = !s2_valid_q || s3_rdy;
  assign up_rdy_o = s2_rdy;

  always_comb begin
    s2_d.drive_en = s1_i.drive_en;
    s2_d.p_kp     = $signed({1'b0, cfg_i.kp_gain}) * s1_i.err;
    s2_d.p_ki     = $signed({1'b0, cfg_i.ki_times_dt}) * s1_i.sum;
    s2_d.p_kd     = $signed({1'b0, cfg_i.kd_over_dt}) * s1_i.de;
    s2_d.err      = s1_i.err;
    s2_d.busy     = s1_i.busy;
    s2_d.fin      = s1_i.fin;
  end

  always_comb begin
    s3_d.drive_en = s2_q.drive_en;
    s3_d.acc      = ACC_W'(s2_q.p_kp) + ACC_W'(s2_q.p_ki) + ACC_W'(s2_q.p_kd);
    s3_d.err      = s2_q.err;
    s3_d.busy     = s2_q.busy;
    s3_d.fin      = s2_q.fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_valid_q <= up_valid_i;
      end
      if (s3_rdy) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && up_valid_i) begin
      s2_q <= s2_d;
    end
    if (s3_rdy && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign s3_o    = s3_q;

endmodule

// File: design/tapid_out.sv
// ----------------------------------------------------------------------------
// tapid_out
// Drive magnitude clamp, sign restore and the result register.
// ----------------------------------------------------------------------------
module tapid_out
  import tapid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               up_valid_i,
  output logic               up_rdy_o,
  input  s3_t                s3_i,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [8:0]  drive_level_o,
  output logic signed [15:0] angle_error_o,
  output logic               busy_res_o,
  output logic               finished_o
);

  localparam int MHI_W = ACC_W - FRAC_W;

  logic               valid_q;
  logic signed [8:0]  drive_q, drive_d;
  logic signed [15:0] err_q;
  logic               busy_q, fin_q;

  logic               neg;
  logic [ACC_W-1:0]   mag;
  logic [MHI_W-1:0]   mag_hi;
  logic               below_min, above_max;
  logic [7:0]         drv_mag;

  assign up_rdy_o = !valid_q || !out_stall_i;

  // Zero counts as positive
  assign neg    = s3_i.acc[ACC_W-1];
  assign mag    = neg ? ACC_W'(0) - ACC_W'(s3_i.acc) : ACC_W'(s3_i.acc);
  assign mag_hi = mag[ACC_W-1:FRAC_W];

  assign below_min = mag_hi < MHI_W'(cfg_i.min_speed);
  assign above_max = (mag_hi > MHI_W'(cfg_i.max_speed))
                  || ((mag_hi == MHI_W'(cfg_i.max_speed)) && (mag[FRAC_W-1:0] != '0));

  always_comb begin
    priority if (below_min) drv_mag = cfg_i.min_speed;
    else if (above_max)     drv_mag = cfg_i.max_speed;
    else                    drv_mag = mag_hi[7:0];
  end

  always_comb begin
    if (!s3_i.drive_en) begin
      drive_d = '0;
    end else if (neg) begin
      drive_d = 9'sd0 - $signed({1'b0, drv_mag});
    end else begin
      drive_d = $signed({1'b0, drv_mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_rdy_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_rdy_o && up_valid_i) begin
      drive_q <= drive_d;
      err_q   <= s3_i.err;
      busy_q  <= s3_i.busy;
      fin_q   <= s3_i.fin;
    end
  end

  assign out_valid_o   = valid_q;
  assign drive_level_o = drive_q;
  assign angle_error_o = err_q;
  assign busy_res_o    = busy_q;
  assign finished_o    = fin_q;

endmodule

// File: design/turn_angle_pid_with_settle.sv
// ----------------------------------------------------------------------------
// turn_angle_pid_with_settle
// Heading PID with angle wrap, saturating integral and settle counting.
// ----------------------------------------------------------------------------
// Path: state register loads at acceptance, then multiplier, accumulate and
//   clamp/result registers; turn state updates in the state stage.
// Throughput: one request per cycle while out_stall_i does not back up the pipe.
// Reset: asynchronous, clears the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
module turn_angle_pid_with_settle
  import tapid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic signed [15:0]    target_angle_i,
  input  logic signed [15:0]    yaw_reading_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [8:0]     drive_level_o,
  output logic signed [15:0]    angle_error_o,
  output logic                  busy_res_o,
  output logic                  finished_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  s1_t  s1;
  s3_t  s3;
  logic in_rdy, s1_valid, mac_rdy, s3_valid, out_rdy;

  tapid_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  tapid_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_rdy_o       (in_rdy),
    .req_type_i     (req_type_i),
    .target_angle_i (target_angle_i),
    .yaw_reading_i  (yaw_reading_i),
    .cfg_i          (cfg),
    .dn_rdy_i       (mac_rdy),
    .valid_o        (s1_valid),
    .s1_o           (s1)
  );

  tapid_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s1_valid),
    .up_rdy_o   (mac_rdy),
    .s1_i       (s1),
    .cfg_i      (cfg),
    .dn_rdy_i   (out_rdy),
    .valid_o    (s3_valid),
    .s3_o       (s3)
  );

  tapid_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .up_valid_i    (s3_valid),
    .up_rdy_o      (out_rdy),
    .s3_i          (s3),
    .cfg_i         (cfg),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_level_o (drive_level_o),
    .angle_error_o (angle_error_o),
    .busy_res_o    (busy_res_o),
    .finished_o    (finished_o)
  );

  assign in_stall_o = !in_rdy;

endmodule

// File: design/tapid_chk.sv
// ----------------------------------------------------------------------------
// tapid_chk
// Port-level checks for the heading PID, bound to the top level.
// ----------------------------------------------------------------------------
module tapid_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [8:0]  drive_level_o,
  input logic signed [15:0] angle_error_o,
  input logic               busy_res_o,
  input logic               finished_o
);

  // A finishing sample ends the turn
  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> !busy_res_o)
    else $error("finished result still reports busy");

  // Idle result carries no drive and no error
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o && !finished_o |-> drive_level_o == 9'sd0
      && angle_error_o == 16'sd0)
    else $error("idle result is not zero");

  // Wrapped error stays within a half turn
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_error_o >= -16'sd18000 && angle_error_o <= 16'sd18000)
    else $error("angle error outside half turn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_level_o)
      && $stable(angle_error_o) && $stable(busy_res_o) && $stable(finished_o))
    else $error("stalled result changed");

endmodule

bind turn_angle_pid_with_settle tapid_chk u_tapid_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_level_o (drive_level_o),
  .angle_error_o (angle_error_o),
  .busy_res_o    (busy_res_o),
  .finished_o    (finished_o)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heading PID with settle counting. Requests are
// predicted at acceptance and each result is compared field by field, in
// order, under random sender bursts, receiver stalls and register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tapid_pkg::*;

  localparam int LATENCY      = 4;
  localparam int DRAIN_CYCLES = 3 * LATENCY;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_PHASE   = 4;
  localparam int RAND_PHASES  = 7;
  localparam int RAND_ITEMS   = 160;
  localparam int MAX_PRINTED  = 40;
  localparam int HALF_CDEG    = 18000;
  localparam int FULL_CDEG    = 36000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  typedef struct packed {
    req_e               kind;
    logic signed [15:0] target;
    logic signed [15:0] yaw;
  } turn_req_t;

  typedef struct packed {
    logic signed [8:0]  drive;
    logic signed [15:0] err;
    logic               busy;
    logic               fin;
  } pid_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i = 1'b0;
  logic signed [15:0]    target_angle_i = '0;
  logic signed [15:0]    yaw_reading_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [8:0]     drive_level_o;
  logic signed [15:0]    angle_error_o;
  logic                  busy_res_o;
  logic                  finished_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  turn_req_t request_q[$];
  pid_res_t  pid_result_q[$];

  // predictor copy of the registers and the turn state
  logic [23:0] kp_r, ki_r, kd_r;
  logic [14:0] bound_r;
  logic [7:0]  max_r, min_r;
  logic [3:0]  settle_r;
  int          start_yaw_s, goal_s, last_err_s, sum_s, settle_left_s;
  bit          running_s, first_s;

  int          n_errors, n_accepted, n_results, n_finished, n_settings;
  int          queued_in_phase, quiet_cycles, phase_id = -1;
  int          burst_left, gap_left, stall_left, stall_tick;
  bit          req_taken, hold_off;
  stall_mode_e stall_mode;
  pid_res_t    exp_r;

  turn_angle_pid_with_settle dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .target_angle_i (target_angle_i),
    .yaw_reading_i  (yaw_reading_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_level_o  (drive_level_o),
    .angle_error_o  (angle_error_o),
    .busy_res_o     (busy_res_o),
    .finished_o     (finished_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int twice_bound();
    int t;
    t = 2 * int'(bound_r);
    return (t > 32767) ? 32767 : t;
  endfunction

  function automatic int wrap_cdeg(int a);
    while (a > HALF_CDEG) a -= FULL_CDEG;
    while (a < -HALF_CDEG) a += FULL_CDEG;
    return a;
  endfunction

  function automatic int rand_gain();
    int sh;
    sh = $urandom_range(0, 24);
    return int'($urandom & ((32'd1 << sh) - 32'd1));
  endfunction

  // One request through the controller; queues the result it must produce.
  task automatic pid_step(input turn_req_t rq);
    int       err, prev, pabs;
    longint   sum, acc, mag, lo, hi, d;
    pid_res_t r;
    r = '0;
    if (rq.kind == REQ_START) begin
      goal_s        = int'($signed(rq.target));
      start_yaw_s   = int'($signed(rq.yaw));
      sum_s         = 0;
      last_err_s    = twice_bound();
      settle_left_s = settle_r;
      running_s     = 1'b1;
      first_s       = 1'b1;
    end else if (running_s) begin
      // settle counter looks at the error left by the previous sample
      pabs = (last_err_s < 0) ? -last_err_s : last_err_s;
      if (pabs < int'(bound_r)) begin
        if (settle_left_s > 0) settle_left_s--;
      end else begin
        settle_left_s = settle_r;
      end
      err = wrap_cdeg(goal_s - (int'($signed(rq.yaw)) - start_yaw_s));
      sum = longint'(sum_s) + err;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      sum_s = int'(sum);
      prev = first_s ? 0 : last_err_s;
      acc = longint'(kp_r) * err + longint'(ki_r) * sum_s + longint'(kd_r) * (err - prev);
      mag = (acc < 0) ? -acc : acc;
      lo  = longint'(min_r) << 16;
      hi  = longint'(max_r) << 16;
      if (mag < lo) d = min_r;
      else if (mag > hi) d = max_r;
      else d = mag >>> 16;
      r.drive    = 9'((acc < 0) ? -d : d);
      r.err      = 16'(err);
      last_err_s = err;
      first_s    = 1'b0;
      if (settle_left_s == 0) begin
        r.fin     = 1'b1;
        running_s = 1'b0;
      end
    end
    r.busy = running_s;
    pid_result_q = {pid_result_q, r};
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("mismatch %0d: %s got %0d expected %0d (result %0d)",
               n_errors, what, got, want, n_results);
  endtask

  task automatic push_req(req_e k, int t, int y);
    turn_req_t r;
    r.kind   = k;
    r.target = 16'(t);
    r.yaw    = 16'(y);
    request_q = {request_q, r};
    queued_in_phase++;
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    logic [23:0] v;
    v = 24'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_KP:     kp_r     = v;
      CFG_KI:     ki_r     = v;
      CFG_KD:     kd_r     = v;
      CFG_BOUND:  bound_r  = v[14:0];
      CFG_MAX:    max_r    = v[7:0];
      CFG_MIN:    min_r    = v[7:0];
      CFG_SETTLE: settle_r = v[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(int kp, int ki, int kd, int bound, int max_s, int min_s,
                                int settle);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_KD, kd);
    write_reg(CFG_BOUND, bound);
    write_reg(CFG_MAX, max_s);
    write_reg(CFG_MIN, min_s);
    write_reg(CFG_SETTLE, settle);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || pid_result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Start, an approach toward the goal, then jitter around it so the turn settles.
  task automatic gen_turn();
    int tgt, y0, n, m, j, e, k;
    tgt = int'($urandom_range(0, FULL_CDEG)) - HALF_CDEG;
    y0  = int'($urandom_range(0, FULL_CDEG)) - HALF_CDEG;
    n   = $urandom_range(1, 10);
    push_req(REQ_START, tgt, y0);
    for (k = 1; k <= n; k++)
      push_req(REQ_SAMPLE, $urandom, wrap_cdeg(y0 + tgt - (tgt * (n - k)) / n));
    j = 0;
    if (bound_r > 1)
      j = $urandom_range(0, (int'(bound_r) > 3001) ? 3000 : int'(bound_r) - 1);
    if ($urandom_range(0, 7) == 0) j += $urandom_range(1, 40);
    m = int'(settle_r) + $urandom_range(1, 3);
    for (k = 0; k < m; k++) begin
      e = int'($urandom_range(0, 2 * j)) - j;
      push_req(REQ_SAMPLE, $urandom, wrap_cdeg(y0 + tgt - e));
    end
  endtask

  task automatic gen_random_phase();
    queued_in_phase = 0;
    while (queued_in_phase < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: push_req(req_e'($urandom_range(0, 1)), $urandom, $urandom);
        1: begin
          push_req(REQ_START, $urandom, $urandom);
          repeat ($urandom_range(1, 4)) push_req(REQ_SAMPLE, $urandom, $urandom);
        end
        default: gen_turn();
      endcase
    end
  endtask

  // request side: accept and predict
  always @(posedge clk_i) begin
    req_taken = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pid_step(request_q.pop_front());
      req_taken = 1'b1;
      n_accepted++;
    end
  end

  // request side: bursts with gaps; a stalled request is held as is
  always @(negedge clk_i) begin
    if (!(in_valid_i && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_valid_i     <= 1'b1;
        req_type_i     <= request_q[0].kind;
        target_angle_i <= request_q[0].target;
        yaw_reading_i  <= request_q[0].yaw;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall pattern
  always @(negedge clk_i) begin
    logic s;
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_LIGHT:    s = ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    s = ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: s = (stall_tick % 3 == 0);
      default:        s = 1'b0;
    endcase
    out_stall_i <= hold_off || s;
  end

  // long receiver hold-off so the pipeline backs up into the request side
  initial begin
    hold_off = 1'b0;
    wait (phase_id == HOLD_PHASE);
    repeat (25) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pid_result_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, 0);
      end else begin
        exp_r = pid_result_q.pop_front();
        if (drive_level_o !== exp_r.drive)
          report_mismatch("drive_level", drive_level_o, $signed(exp_r.drive));
        if (angle_error_o !== exp_r.err)
          report_mismatch("angle_error", angle_error_o, $signed(exp_r.err));
        if (busy_res_o !== exp_r.busy)
          report_mismatch("busy_res", busy_res_o, exp_r.busy);
        if (finished_o !== exp_r.fin)
          report_mismatch("finished", finished_o, exp_r.fin);
        if (exp_r.fin) n_finished++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    kp_r          = CFG_RST.kp_gain;
    ki_r          = CFG_RST.ki_times_dt;
    kd_r          = CFG_RST.kd_over_dt;
    bound_r       = CFG_RST.error_bound;
    max_r         = CFG_RST.max_speed;
    min_r         = CFG_RST.min_speed;
    settle_r      = CFG_RST.settle_count;
    start_yaw_s   = 0;
    goal_s        = 0;
    sum_s         = 0;
    settle_left_s = 0;
    last_err_s    = twice_bound();
    running_s     = 1'b0;
    first_s       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, register defaults
    push_req(REQ_SAMPLE, 32767, -32768);      // sample while idle
    push_req(REQ_START, 0, 0);
    repeat (9) push_req(REQ_SAMPLE, 0, 0);    // zero error, settles on the ninth
    push_req(REQ_SAMPLE, -1, 100);
    push_req(REQ_START, 18000, -18000);
    push_req(REQ_SAMPLE, 0, 18000);
    push_req(REQ_START, -18000, 18000);       // restart mid-turn
    push_req(REQ_SAMPLE, 0, -18000);
    push_req(REQ_START, 32767, -32768);       // raw error beyond a half turn
    push_req(REQ_SAMPLE, 0, 32767);
    push_req(REQ_SAMPLE, 0, -32768);
    push_req(REQ_START, -32768, 32767);
    push_req(REQ_SAMPLE, 0, -32768);
    push_req(REQ_START, 1000, 0);
    push_req(REQ_SAMPLE, 0, 0);
    push_req(REQ_SAMPLE, 0, 1005);            // below the minimum drive
    wait_drained();

    // settle count zero, saturated twice-bound, minimum above maximum
    apply_settings(6554, 0, 0, 20000, 5, 100, 0);
    push_req(REQ_START, 1000, 0);
    push_req(REQ_SAMPLE, 0, 0);
    push_req(REQ_SAMPLE, 0, 0);
    push_req(REQ_START, -500, 100);
    push_req(REQ_SAMPLE, 0, 200);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: apply_settings(6554, 40, 2000, 10, 128, 13, 8);
        1: apply_settings(0, 0, 0, 0, 0, 0, 0);
        2: apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32767, 255, 255, 15);
        3: apply_settings(30000, 500, 20000, 200, 40, 100, 3);
        6: apply_settings(rand_gain(), $urandom_range(0, 64), rand_gain(), 18000, 128, 128, 1);
        default: apply_settings(rand_gain(), ($urandom_range(0, 1) != 0) ? rand_gain()
                                : $urandom_range(0, 64), rand_gain(), $urandom_range(0, 300),
                                $urandom_range(0, 128), $urandom_range(0, 40),
                                $urandom_range(0, 15));
      endcase
      phase_id = p;
      gen_random_phase();
      wait_drained();
    end

    if (pid_result_q.size() != 0)
      report_mismatch("results never delivered", 0, pid_result_q.size());
    $display("covered %0d requests and %0d checked results over %0d register settings",
             n_accepted, n_results, n_settings);
    $display("%0d turns settled; idle samples, restarts, wide angle wrap and clamp corners hit",
             n_finished);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
